[src/ctf_pkg.sv]
// shared types and constants for the csv field tokenizer
package ctf_pkg;

    localparam int MAX_FIELDS = 255;
    localparam logic [7:0] FIELD_BOUND = (MAX_FIELDS < 255) ? 8'(MAX_FIELDS) : 8'd255;

    localparam logic [7:0] CH_QUOTE      = 8'd34;
    localparam logic [7:0] CH_NEWLINE    = 8'd10;
    localparam logic [7:0] SEP_RESET     = 8'd44;
    localparam logic [31:0] LINE_MAX     = 32'hFFFF_FFFF;
    localparam logic       REG_SEPARATOR = 1'b0;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_QUOTED  = 2'd1,
        MODE_PENDING = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        logic       action;
        logic [7:0] text_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       token_kind;
        logic [7:0]  data_byte;
        logic [7:0]  row_field_count;
        logic [7:0]  expected_count;
        logic [31:0] row_number;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_parse_res;

endpackage

[src/csv_field_tokenizer.sv]
// top level: input register, parser, result register and apb configuration
// one byte or end-of-stream marker per cycle unless stalled, at most one token per item
// a result passes the input register and then the result register before it is shown
// sustained throughput one item per cycle while the output is not stalled; both registers stall together
// synchronous active-low reset: unquoted mode, counts cleared, line 1, separator 44
module csv_field_tokenizer
    import ctf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       adv, in_take;
    logic [7:0] separator;
    t_parse_res res;

    assign adv        = r_in_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    ctf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_separator (separator)
    );

    ctf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (adv),
        .i_item      (r_in_item),
        .i_separator (separator),
        .o_res       (res)
    );

    ctf_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[src/ctf_cfg_regs.sv]
// apb configuration register holding the separator byte
module ctf_cfg_regs
    import ctf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_separator
);

    logic [7:0] r_sep;
    logic       wr_sep;

    assign pready = 1'b1;
    assign wr_sep = psel && penable && pwrite && (paddr[2] == REG_SEPARATOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (wr_sep) begin
            r_sep <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SEPARATOR) begin
            prdata = {24'd0, r_sep};
        end
    end

    assign o_separator = r_sep;

endmodule

[src/ctf_parser.sv]
// parse state and per-byte token decision
module ctf_parser
    import ctf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_in_item   i_item,
    input  logic [7:0] i_separator,
    output t_parse_res o_res
);

    t_mode       r_mode, n_mode, plain_mode;
    logic [7:0]  r_fields, n_fields;
    logic        r_content, n_content;
    logic [7:0]  r_expected, n_expected;
    logic [31:0] r_line, n_line;
    logic        r_failed, n_failed;

    logic       live, is_q, is_nl, is_sep, plain_path, end_req;
    logic       row_over, row_mismatch, sep_over;
    logic [8:0] count9;
    logic [7:0] count8, row_expected;

    assign live   = i_fire && !r_failed;
    assign is_q   = (i_item.text_byte == CH_QUOTE);
    assign is_nl  = (i_item.text_byte == CH_NEWLINE);
    assign is_sep = (i_item.text_byte == i_separator);

    assign plain_path = (r_mode != MODE_QUOTED) && !((r_mode == MODE_PENDING) && is_q);
    assign end_req    = live && (i_item.action ? ((r_fields != 8'd0) || r_content)
                                               : (plain_path && is_nl));

    assign count9       = {1'b0, r_fields} + 9'd1;
    assign count8       = count9[7:0];
    assign row_over     = (count9 > {1'b0, FIELD_BOUND});
    assign row_mismatch = (r_expected != 8'd0) && (r_expected != count8);
    assign row_expected = (r_expected == 8'd0) ? count8 : r_expected;
    assign sep_over     = (r_fields >= FIELD_BOUND);

    assign plain_mode = (is_q && !is_nl && !is_sep) ? MODE_QUOTED : MODE_PLAIN;

    // next parse mode
    always_comb begin
        n_mode = r_mode;
        if (live) begin
            if (i_item.action) begin
                n_mode = MODE_PLAIN;
            end else begin
                case (r_mode)
                    MODE_QUOTED:  n_mode = is_q ? MODE_PENDING : MODE_QUOTED;
                    MODE_PENDING: n_mode = is_q ? MODE_QUOTED : plain_mode;
                    default:      n_mode = plain_mode;
                endcase
            end
        end
    end

    // result and counters
    always_comb begin
        o_res.valid                = 1'b0;
        o_res.item.token_kind      = KIND_DATA;
        o_res.item.data_byte       = 8'd0;
        o_res.item.row_field_count = 8'd0;
        o_res.item.expected_count  = r_expected;
        o_res.item.row_number      = r_line;
        n_fields   = r_fields;
        n_content  = r_content;
        n_expected = r_expected;
        n_line     = r_line;
        n_failed   = r_failed;
        if (end_req) begin
            o_res.valid = 1'b1;
            if (row_over) begin
                o_res.item.token_kind      = KIND_ERROR;
                o_res.item.row_field_count = FIELD_BOUND;
                n_failed                   = 1'b1;
            end else if (row_mismatch) begin
                o_res.item.token_kind      = KIND_ERROR;
                o_res.item.row_field_count = count8;
                n_failed                   = 1'b1;
            end else begin
                o_res.item.token_kind      = KIND_ROW;
                o_res.item.row_field_count = count8;
                o_res.item.expected_count  = row_expected;
                n_expected                 = row_expected;
                n_fields                   = 8'd0;
                n_content                  = 1'b0;
                if (r_line != LINE_MAX) begin
                    n_line = r_line + 32'd1;
                end
            end
        end else if (live && !i_item.action) begin
            if (r_mode == MODE_QUOTED) begin
                n_content = 1'b1;
                if (!is_q) begin
                    o_res.valid          = 1'b1;
                    o_res.item.data_byte = i_item.text_byte;
                end
            end else if ((r_mode == MODE_PENDING) && is_q) begin
                o_res.valid          = 1'b1;
                o_res.item.data_byte = CH_QUOTE;
            end else begin
                n_content = 1'b1;
                if (is_sep) begin
                    o_res.valid = 1'b1;
                    if (sep_over) begin
                        o_res.item.token_kind      = KIND_ERROR;
                        o_res.item.row_field_count = FIELD_BOUND;
                        n_failed                   = 1'b1;
                    end else begin
                        o_res.item.token_kind      = KIND_FIELD;
                        o_res.item.row_field_count = count8;
                        n_fields                   = count8;
                    end
                end else if (!is_q) begin
                    o_res.valid          = 1'b1;
                    o_res.item.data_byte = i_item.text_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PLAIN;
            r_fields   <= 8'd0;
            r_content  <= 1'b0;
            r_expected <= 8'd0;
            r_line     <= 32'd1;
            r_failed   <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_fields   <= n_fields;
            r_content  <= n_content;
            r_expected <= n_expected;
            r_line     <= n_line;
            r_failed   <= n_failed;
        end
    end

    a_failed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("error state left without reset");

    a_error_sets_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.item.token_kind == KIND_ERROR)) |=> r_failed)
        else $error("format error did not stop the parser");

    a_silent_when_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !o_res.valid)
        else $error("result produced after error");

    a_row_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.item.token_kind == KIND_ROW))
            |=> (r_fields == 8'd0) && (r_expected != 8'd0))
        else $error("row end left field count or expected count wrong");

    a_fields_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fields <= FIELD_BOUND)
        else $error("field count beyond bound");

endmodule

[src/ctf_out_reg.sv]
// result register towards the output channel
module ctf_out_reg
    import ctf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_parse_res i_res,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_res.valid;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_res.valid) begin
            r_item <= i_res.item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule
